>>> design/rhrt_pkg.sv
// Package: widths, constants, register codes and sine table for the hue rotation block.
`timescale 1ns / 1ps

package rhrt_pkg;

  localparam int CH_W      = 8;   // one colour channel
  localparam int PIX_W     = 3 * CH_W;
  localparam int HUE_W     = 9;
  localparam int FAC_W     = 16;  // saturation and value gain, Q2.14
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int SIN_W     = 18;  // signed Q1.16
  localparam int CA_W      = 20;  // scaled cos/sin, signed Q.16
  localparam int COEF_W    = 21;  // matrix coefficients, signed Q4.16
  localparam int PROD_W    = COEF_W + CH_W + 1;
  localparam int ACC_W     = PROD_W + 2;

  localparam int          DEG_FULL     = 360;
  localparam int          DEG_QUARTER  = 90;
  localparam int          ONE_Q16      = 65536;
  localparam int          SAT_SHIFT    = 14;
  localparam logic [19:0] RECIP3       = 20'd699051;  // ceil(2^21 / 3)
  localparam int          RECIP3_SHIFT = 21;
  localparam logic [15:0] ROOT_THIRD   = 16'd37837;   // sqrt(1/3), Q.16
  localparam int          GAIN_SHIFT   = 30;
  localparam logic [CH_W-1:0] CH_MAX   = 8'hFF;

  // Coefficient pipe is seven stages from the registers; stall input after a write.
  localparam int          SETTLE_W     = 3;
  localparam logic [SETTLE_W-1:0] SETTLE = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE  = 2'd0,
    REG_SAT  = 2'd1,
    REG_GAIN = 2'd2
  } cfg_reg_t;

  // round(sin(d deg) * 65536) for d = 0..90
  function automatic logic [16:0] quarter_sine(input logic [6:0] d);
    logic [16:0] v;
    begin
      case (d)
        7'd0:  v = 17'd0;      7'd1:  v = 17'd1144;   7'd2:  v = 17'd2287;
        7'd3:  v = 17'd3430;   7'd4:  v = 17'd4572;   7'd5:  v = 17'd5712;
        7'd6:  v = 17'd6850;   7'd7:  v = 17'd7987;   7'd8:  v = 17'd9121;
        7'd9:  v = 17'd10252;  7'd10: v = 17'd11380;  7'd11: v = 17'd12505;
        7'd12: v = 17'd13626;  7'd13: v = 17'd14742;  7'd14: v = 17'd15855;
        7'd15: v = 17'd16962;  7'd16: v = 17'd18064;  7'd17: v = 17'd19161;
        7'd18: v = 17'd20252;  7'd19: v = 17'd21336;  7'd20: v = 17'd22415;
        7'd21: v = 17'd23486;  7'd22: v = 17'd24550;  7'd23: v = 17'd25607;
        7'd24: v = 17'd26656;  7'd25: v = 17'd27697;  7'd26: v = 17'd28729;
        7'd27: v = 17'd29753;  7'd28: v = 17'd30767;  7'd29: v = 17'd31772;
        7'd30: v = 17'd32768;  7'd31: v = 17'd33754;  7'd32: v = 17'd34729;
        7'd33: v = 17'd35693;  7'd34: v = 17'd36647;  7'd35: v = 17'd37590;
        7'd36: v = 17'd38521;  7'd37: v = 17'd39441;  7'd38: v = 17'd40348;
        7'd39: v = 17'd41243;  7'd40: v = 17'd42126;  7'd41: v = 17'd42995;
        7'd42: v = 17'd43852;  7'd43: v = 17'd44695;  7'd44: v = 17'd45525;
        7'd45: v = 17'd46341;  7'd46: v = 17'd47143;  7'd47: v = 17'd47930;
        7'd48: v = 17'd48703;  7'd49: v = 17'd49461;  7'd50: v = 17'd50203;
        7'd51: v = 17'd50931;  7'd52: v = 17'd51643;  7'd53: v = 17'd52339;
        7'd54: v = 17'd53020;  7'd55: v = 17'd53684;  7'd56: v = 17'd54332;
        7'd57: v = 17'd54963;  7'd58: v = 17'd55578;  7'd59: v = 17'd56175;
        7'd60: v = 17'd56756;  7'd61: v = 17'd57319;  7'd62: v = 17'd57865;
        7'd63: v = 17'd58393;  7'd64: v = 17'd58903;  7'd65: v = 17'd59396;
        7'd66: v = 17'd59870;  7'd67: v = 17'd60326;  7'd68: v = 17'd60764;
        7'd69: v = 17'd61183;  7'd70: v = 17'd61584;  7'd71: v = 17'd61966;
        7'd72: v = 17'd62328;  7'd73: v = 17'd62672;  7'd74: v = 17'd62997;
        7'd75: v = 17'd63303;  7'd76: v = 17'd63589;  7'd77: v = 17'd63856;
        7'd78: v = 17'd64104;  7'd79: v = 17'd64332;  7'd80: v = 17'd64540;
        7'd81: v = 17'd64729;  7'd82: v = 17'd64898;  7'd83: v = 17'd65048;
        7'd84: v = 17'd65177;  7'd85: v = 17'd65287;  7'd86: v = 17'd65376;
        7'd87: v = 17'd65446;  7'd88: v = 17'd65496;  7'd89: v = 17'd65526;
        7'd90: v = 17'd65536;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

  // Signed Q1.16 sine of an angle already reduced to 0..359
  function automatic logic signed [SIN_W-1:0] sine_q16(input logic [HUE_W-1:0] d);
    logic [HUE_W-1:0] idx;
    logic             neg;
    logic [16:0]      mag;
    begin
      neg = 1'b0;
      if (d <= HUE_W'(DEG_QUARTER)) begin
        idx = d;
      end else if (d <= HUE_W'(2 * DEG_QUARTER)) begin
        idx = HUE_W'(2 * DEG_QUARTER) - d;
      end else if (d <= HUE_W'(3 * DEG_QUARTER)) begin
        idx = d - HUE_W'(2 * DEG_QUARTER);
        neg = 1'b1;
      end else begin
        idx = HUE_W'(DEG_FULL) - d;
        neg = 1'b1;
      end
      mag = quarter_sine(idx[6:0]);
      return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  endfunction

endpackage

>>> design/rgb_hsv_rotation_transform.sv
// Top level: pipelined RGB hue rotation with saturation and value gain.
`timescale 1ns / 1ps

// Channel   Handshake        Word                     Notes
// --------  ---------------  -----------------------  ------------------------------
// input     start, busy      pixel_in  [23:0]         taken when start && !busy
// result    done             pixel_out [23:0]         one cycle, cannot be held off
// config    wr_en            wr_index, wr_data [15:0] index 0 hue, 1 sat, 2 gain
//
// One word per clock while busy is low. A word passes the input register, products,
// sums, gain partial products and clamp/output stages in that order; done and the
// word are registered together in the last of them.
// Matrix coefficients come from a separate seven-stage pipe fed by the registers; busy
// stays high after a register write and after reset while it settles.
// Reset clears the valid bits, loads the registers with their defaults and raises busy.
// The receiver cannot stall, so the pixel pipe never stops.

module rgb_hsv_rotation_transform (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [rhrt_pkg::PIX_W-1:0]       pixel_in,
  output logic                             done,
  output logic [rhrt_pkg::PIX_W-1:0]       pixel_out,
  input  logic                             wr_en,
  input  logic [rhrt_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [rhrt_pkg::CFG_DAT_W-1:0]   wr_data
);
  import rhrt_pkg::*;

  // ---------------------------------------------------------------------------------
  // Configuration registers and settle counter
  // ---------------------------------------------------------------------------------
  logic [HUE_W-1:0]    hue_degrees;
  logic [FAC_W-1:0]    saturation;
  logic [FAC_W-1:0]    value_gain;
  logic [SETTLE_W-1:0] settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_degrees <= '0;
      saturation  <= FAC_W'(16384);
      value_gain  <= FAC_W'(16384);
      settle      <= SETTLE;
    end else begin
      if (wr_en) begin
        settle <= SETTLE;
        unique case (wr_index)
          REG_HUE:  hue_degrees <= wr_data[HUE_W-1:0];
          REG_SAT:  saturation  <= wr_data[FAC_W-1:0];
          REG_GAIN: value_gain  <= wr_data[FAC_W-1:0];
          default:  ;  // beyond the list: ignored
        endcase
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  assign busy = (settle != '0);

  // ---------------------------------------------------------------------------------
  // Coefficient pipe (runs freely off the registers)
  // ---------------------------------------------------------------------------------
  // C1: hue mod 360, and hue + 90 mod 360 for the cosine
  logic [HUE_W-1:0] hue_s, hue_c;
  logic [HUE_W:0]   hue_p90;
  logic [HUE_W-1:0] hue_m;

  always_comb begin
    hue_m   = (hue_degrees >= HUE_W'(DEG_FULL)) ? hue_degrees - HUE_W'(DEG_FULL)
                                                : hue_degrees;
    hue_p90 = {1'b0, hue_m} + (HUE_W + 1)'(DEG_QUARTER);
  end

  always_ff @(posedge clk) begin
    hue_s <= hue_m;
    hue_c <= (hue_p90 >= (HUE_W + 1)'(DEG_FULL)) ? HUE_W'(hue_p90 - (HUE_W + 1)'(DEG_FULL))
                                                  : hue_p90[HUE_W-1:0];
  end

  // C2: table lookup
  logic signed [SIN_W-1:0] cos_q, sin_q;
  always_ff @(posedge clk) begin
    cos_q <= sine_q16(hue_c);
    sin_q <= sine_q16(hue_s);
  end

  // C3: saturation * cos / sin
  logic signed [FAC_W+SIN_W:0] sat_cos, sat_sin;
  always_ff @(posedge clk) begin
    sat_cos <= $signed({1'b0, saturation}) * cos_q;
    sat_sin <= $signed({1'b0, saturation}) * sin_q;
  end

  // C4: divide by 2^14, truncating toward zero
  logic [FAC_W+SIN_W:0]  cos_mag, sin_mag;
  logic signed [CA_W-1:0] ca, sa;
  always_comb begin
    cos_mag = sat_cos[FAC_W+SIN_W] ? $unsigned(-sat_cos) : $unsigned(sat_cos);
    sin_mag = sat_sin[FAC_W+SIN_W] ? $unsigned(-sat_sin) : $unsigned(sat_sin);
  end

  always_ff @(posedge clk) begin
    ca <= sat_cos[FAC_W+SIN_W] ? -$signed({1'b0, cos_mag[SAT_SHIFT+CA_W-2:SAT_SHIFT]})
                               :  $signed({1'b0, cos_mag[SAT_SHIFT+CA_W-2:SAT_SHIFT]});
    sa <= sat_sin[FAC_W+SIN_W] ? -$signed({1'b0, sin_mag[SAT_SHIFT+CA_W-2:SAT_SHIFT]})
                               :  $signed({1'b0, sin_mag[SAT_SHIFT+CA_W-2:SAT_SHIFT]});
  end

  // C5: (1 - ca) / 3 by reciprocal, sqrt(1/3) * sa, both on magnitudes
  logic signed [CA_W:0]   num;
  logic [CA_W-1:0]        num_mag;
  logic [CA_W-2:0]        sa_mag;
  logic [CA_W+19:0]       t_prod;
  logic [CA_W+14:0]       u_prod;
  logic                   t_neg, u_neg;
  logic signed [CA_W-1:0] ca_d5;

  always_comb begin
    num     = (CA_W + 1)'(ONE_Q16) - (CA_W + 1)'(ca);
    num_mag = num[CA_W] ? CA_W'($unsigned(-num)) : CA_W'($unsigned(num));
    sa_mag  = sa[CA_W-1] ? (CA_W - 1)'($unsigned(-sa)) : (CA_W - 1)'($unsigned(sa));
  end

  always_ff @(posedge clk) begin
    t_prod <= num_mag * RECIP3;
    u_prod <= sa_mag * ROOT_THIRD;
    t_neg  <= num[CA_W];
    u_neg  <= sa[CA_W-1];
    ca_d5  <= ca;
  end

  // C6: finish the scaling shifts and restore signs
  logic signed [CA_W-1:0] t_q, u_q;
  logic signed [CA_W-1:0] ca_d6;
  always_ff @(posedge clk) begin
    t_q   <= t_neg ? -$signed({1'b0, t_prod[RECIP3_SHIFT+CA_W-2:RECIP3_SHIFT]})
                   :  $signed({1'b0, t_prod[RECIP3_SHIFT+CA_W-2:RECIP3_SHIFT]});
    u_q   <= u_neg ? -$signed({1'b0, u_prod[16+CA_W-2:16]})
                   :  $signed({1'b0, u_prod[16+CA_W-2:16]});
    ca_d6 <= ca_d5;
  end

  // C7: matrix coefficients
  logic signed [COEF_W-1:0] diag, plus, minus;
  always_ff @(posedge clk) begin
    diag  <= COEF_W'(ca_d6) + COEF_W'(t_q);
    plus  <= COEF_W'(t_q)   + COEF_W'(u_q);
    minus <= COEF_W'(t_q)   - COEF_W'(u_q);
  end

  // ---------------------------------------------------------------------------------
  // Pixel pipe
  // ---------------------------------------------------------------------------------
  // S0: input register
  logic             v0;
  logic [PIX_W-1:0] px;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start && !busy;
  end

  always_ff @(posedge clk) begin
    px <= pixel_in;
  end

  // Rows: red (diag, minus, plus), green (plus, diag, minus), blue (minus, plus, diag)
  logic signed [COEF_W-1:0] row_coef [3][3];
  logic [CH_W-1:0]          chan     [3];

  always_comb begin
    chan[0] = px[3*CH_W-1:2*CH_W];
    chan[1] = px[2*CH_W-1:CH_W];
    chan[2] = px[CH_W-1:0];
    row_coef[0][0] = diag;  row_coef[0][1] = minus; row_coef[0][2] = plus;
    row_coef[1][0] = plus;  row_coef[1][1] = diag;  row_coef[1][2] = minus;
    row_coef[2][0] = minus; row_coef[2][1] = plus;  row_coef[2][2] = diag;
  end

  // S1: nine products
  logic                     v1;
  logic signed [PROD_W-1:0] prod [3][3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r][k] <= row_coef[r][k] * $signed({1'b0, chan[k]});
      end
    end
  end

  // S2: dot products
  logic                    v2;
  logic signed [ACC_W-1:0] acc [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      acc[r] <= ACC_W'(prod[r][0]) + ACC_W'(prod[r][1]) + ACC_W'(prod[r][2]);
    end
  end

  // S3: gain as two partial products on the positive dot product
  localparam int LO_W = 15;
  localparam int HI_W = ACC_W - 1 - LO_W;

  logic                    v3;
  logic                    pos   [3];
  logic [HI_W+FAC_W-1:0]   p_hi  [3];
  logic [LO_W+FAC_W-1:0]   p_lo  [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      pos[r]  <= !acc[r][ACC_W-1] && (acc[r] != '0);
      p_hi[r] <= acc[r][ACC_W-2:LO_W] * value_gain;
      p_lo[r] <= acc[r][LO_W-1:0] * value_gain;
    end
  end

  // S4: recombine, shift by 30, clamp to 0..255
  localparam int SUM_W = HI_W + FAC_W + LO_W + 1;

  logic [SUM_W-1:0]            gsum [3];
  logic [SUM_W-GAIN_SHIFT-1:0] gval [3];
  logic [CH_W-1:0]             cout [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      gsum[r] = {1'b0, p_hi[r], {LO_W{1'b0}}} + SUM_W'(p_lo[r]);
      gval[r] = gsum[r][SUM_W-1:GAIN_SHIFT];
      if (!pos[r])
        cout[r] = '0;
      else if (gval[r] > (SUM_W - GAIN_SHIFT)'(CH_MAX))
        cout[r] = CH_MAX;
      else
        cout[r] = gval[r][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v3;
  end

  always_ff @(posedge clk) begin
    pixel_out <= {cout[0], cout[1], cout[2]};
  end

endmodule
